FILE: rtl/html_text_stripper_macros.svh
`ifndef HTML_TEXT_STRIPPER_MACROS_SVH
`define HTML_TEXT_STRIPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define HTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define HTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hts_pkg.sv
package hts_pkg;

  localparam int MAX_OUT_LEN = 4096;
  localparam int LEN_W       = 13;
  localparam int ENT_COUNT   = 7;
  localparam int ENT_MAX     = 6;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = 2;
  localparam int Q_CW        = 3;

  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_OUT_LEN - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_LT   = 3'd1;
  localparam logic [2:0] ENT_GT   = 3'd2;
  localparam logic [2:0] ENT_QUOT = 3'd3;
  localparam logic [2:0] ENT_N39  = 3'd4;
  localparam logic [2:0] ENT_APOS = 3'd5;
  localparam logic [2:0] ENT_NBSP = 3'd6;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_TAG  = 2'd1,
    MODE_ENT  = 2'd2,
    MODE_SKIP = 2'd3
  } mode_t;

  typedef struct packed {
    logic       last;
    logic       has;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0] n;
    item_t      b;
    item_t      a;
  } step_t;

  function automatic logic [47:0] ent_word(input logic [2:0] k);
    logic [47:0] w;
    case (k)
      ENT_AMP:  w = {"&amp;", 8'h00};
      ENT_LT:   w = {"&lt;", 16'h0000};
      ENT_GT:   w = {"&gt;", 16'h0000};
      ENT_QUOT: w = "&quot;";
      ENT_N39:  w = {"&#39;", 8'h00};
      ENT_APOS: w = "&apos;";
      ENT_NBSP: w = "&nbsp;";
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [2:0] pos);
    logic [47:0] w;
    w = ent_word(k) << {pos, 3'b000};
    return w[47:40];
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] k);
    logic [2:0] l;
    case (k)
      ENT_AMP, ENT_N39:                     l = 3'd5;
      ENT_LT, ENT_GT:                       l = 3'd4;
      ENT_QUOT, ENT_APOS, ENT_NBSP:         l = 3'd6;
      default:                              l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] ent_out(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      ENT_AMP:           c = CH_AMP;
      ENT_LT:            c = CH_LT;
      ENT_GT:            c = CH_GT;
      ENT_QUOT:          c = CH_QUOT;
      ENT_N39, ENT_APOS: c = CH_APOS;
      default:           c = CH_SPACE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/hts_scan.sv
module hts_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hts_pkg::LEN_W-1:0] cfg_data,
  input  logic                      fire,
  input  logic [7:0]                text_byte,
  input  logic                      is_last,
  output hts_pkg::step_t            step
);

  hts_pkg::mode_t                   mode, mode_next;
  logic [hts_pkg::ENT_COUNT-1:0]    mask, mask_next;
  logic [2:0]                       ent_len, ent_len_next;
  logic                             after, after_next;
  logic                             held, held_next;
  logic [hts_pkg::LEN_W-1:0]        count, count_next;
  logic [hts_pkg::LEN_W-1:0]        limit;

  logic                             done;
  logic                             em;
  logic [7:0]                       em_byte;
  logic                             wh;
  logic [hts_pkg::ENT_COUNT-1:0]    match;
  logic [hts_pkg::ENT_COUNT-1:0]    full;
  logic [2:0]                       full_k;
  logic                             full_found;
  logic                             is_white;
  logic                             below;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hts_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        limit <= '0;
      end else if (cfg_data > hts_pkg::LEN_W'(hts_pkg::MAX_OUT_LEN)) begin
        limit <= hts_pkg::LIMIT_RESET;
      end else begin
        limit <= cfg_data - hts_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= hts_pkg::MODE_TEXT;
      ent_len <= '0;
      after   <= 1'b1;
      held    <= 1'b0;
      count   <= '0;
    end else if (fire) begin
      mode    <= mode_next;
      ent_len <= ent_len_next;
      after   <= after_next;
      held    <= held_next;
      count   <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mask <= mask_next;
    end
  end

  always_comb begin
    is_white = (text_byte == hts_pkg::CH_SPACE) ||
               (text_byte >= hts_pkg::CH_TAB && text_byte <= hts_pkg::CH_CR);
    below    = (count + hts_pkg::LEN_W'(held)) < limit;
    done     = (text_byte == hts_pkg::CH_NUL) || is_last;

    full_k     = '0;
    full_found = 1'b0;
    for (int k = 0; k < hts_pkg::ENT_COUNT; k++) begin
      match[k] = mask[k] && (ent_len < hts_pkg::ent_len(3'(k))) &&
                 (hts_pkg::ent_char(3'(k), ent_len) == text_byte);
      full[k]  = match[k] && ((ent_len + 3'd1) == hts_pkg::ent_len(3'(k)));
      if (full[k] && !full_found) begin
        full_found = 1'b1;
        full_k     = 3'(k);
      end
    end

    mode_next    = mode;
    mask_next    = mask;
    ent_len_next = ent_len;
    after_next   = after;
    held_next    = held;
    count_next   = count;
    em           = 1'b0;
    em_byte      = text_byte;
    wh           = 1'b0;
    step         = '0;

    if (text_byte != hts_pkg::CH_NUL && below) begin
      unique case (mode)
        hts_pkg::MODE_TAG: begin
          if (text_byte == hts_pkg::CH_GT) begin
            mode_next = hts_pkg::MODE_TEXT;
          end
        end
        hts_pkg::MODE_SKIP: begin
          if (text_byte == hts_pkg::CH_SEMI) begin
            mode_next = hts_pkg::MODE_TEXT;
          end
        end
        hts_pkg::MODE_ENT: begin
          if (ent_len >= 3'(hts_pkg::ENT_MAX) || (!full_found && match == '0)) begin
            mode_next    = (text_byte == hts_pkg::CH_SEMI) ? hts_pkg::MODE_TEXT
                                                           : hts_pkg::MODE_SKIP;
            ent_len_next = '0;
          end else if (full_found) begin
            if (full_k == hts_pkg::ENT_NBSP) begin
              wh = 1'b1;
            end else begin
              em      = 1'b1;
              em_byte = hts_pkg::ent_out(full_k);
            end
            mode_next    = hts_pkg::MODE_TEXT;
            ent_len_next = '0;
          end else begin
            mask_next    = match;
            ent_len_next = ent_len + 3'd1;
          end
        end
        default: begin
          if (text_byte == hts_pkg::CH_LT) begin
            mode_next = hts_pkg::MODE_TAG;
          end else if (text_byte == hts_pkg::CH_AMP) begin
            mode_next    = hts_pkg::MODE_ENT;
            mask_next    = '1;
            ent_len_next = 3'd1;
          end else if (is_white) begin
            wh = 1'b1;
          end else begin
            em         = 1'b1;
            after_next = 1'b0;
          end
        end
      endcase
    end

    if (wh && !after) begin
      held_next  = 1'b1;
      after_next = 1'b1;
    end

    if (em) begin
      if (held) begin
        step.a     = '{last: 1'b0, has: 1'b1, data: hts_pkg::CH_SPACE};
        step.b     = '{last: 1'b0, has: 1'b1, data: em_byte};
        step.n     = 2'd2;
        count_next = count + hts_pkg::LEN_W'(2);
        held_next  = 1'b0;
      end else begin
        step.a     = '{last: 1'b0, has: 1'b1, data: em_byte};
        step.n     = 2'd1;
        count_next = count + hts_pkg::LEN_W'(1);
      end
    end

    if (done) begin
      case (step.n)
        2'd0: begin
          step.a = '{last: 1'b1, has: 1'b0, data: 8'h00};
          step.n = 2'd1;
        end
        2'd1:    step.a.last = 1'b1;
        default: step.b.last = 1'b1;
      endcase
      mode_next    = hts_pkg::MODE_TEXT;
      ent_len_next = '0;
      after_next   = 1'b1;
      held_next    = 1'b0;
      count_next   = '0;
    end
  end

`include "html_text_stripper_macros.svh"

  `HTS_ASSERT_NXT(a_done_clears, clk, rst, fire && done, count == '0 && !held && mode == hts_pkg::MODE_TEXT, "string state not cleared at end")
  `HTS_ASSERT_IMP(a_held_after, clk, rst, held, after, "held space without collapse flag")
  `HTS_ASSERT_IMP(a_count_limit, clk, rst, fire && step.n == 2'd2, held && below, "two words without held space")

endmodule

FILE: rtl/hts_outq.sv
module hts_outq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hts_pkg::step_t step,
  output logic           room,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);

  hts_pkg::item_t            mem [hts_pkg::Q_DEPTH];
  logic [hts_pkg::Q_AW-1:0]  wr_ptr, rd_ptr;
  logic [hts_pkg::Q_CW-1:0]  count, count_next;
  logic [1:0]                push_n;
  logic                      pop;

  assign push_n   = push ? step.n : 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign room     = (count <= hts_pkg::Q_CW'(hts_pkg::Q_DEPTH - 2));
  assign m_tdata  = mem[rd_ptr].data;
  assign m_tuser  = mem[rd_ptr].has;
  assign m_tlast  = mem[rd_ptr].last;

  always_comb begin
    count_next = count + hts_pkg::Q_CW'(push_n) - hts_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + hts_pkg::Q_AW'(push_n);
      rd_ptr <= rd_ptr + hts_pkg::Q_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= step.a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + hts_pkg::Q_AW'(1)] <= step.b;
    end
  end

`include "html_text_stripper_macros.svh"

  `HTS_ASSERT_IMP(a_no_overflow, clk, rst, 1'b1, count <= hts_pkg::Q_CW'(hts_pkg::Q_DEPTH), "output queue overflow")
  `HTS_ASSERT_IMP(a_push_room, clk, rst, push_n != 2'd0, room, "push without room")
  `HTS_ASSERT_NXT(a_drain, clk, rst, pop && push_n == 2'd0 && count == hts_pkg::Q_CW'(1), !m_tvalid, "queue not empty after last pop")

endmodule

FILE: rtl/html_text_stripper.sv
// HTML text cleaner. Send one character per word on the s_ side (s_tlast marks the final
// character, a zero byte also ends the string); cleaned words come out on the m_ side with
// m_tuser high when m_tdata carries a character and m_tlast on the final word of the string.
// Tags are removed, the common entities are decoded, whitespace runs collapse to one space
// and output stops at cfg_data - 1 characters per string (write cfg_data only while idle;
// after reset and for larger values it is 4096). A character is accepted every cycle and
// waits in the input register for queue room; each yields zero, one or two words. The output
// side drains one word per cycle, so input stalls only when the four-entry output queue
// lacks room for two words, that is when the sink backpressures or a held space is released.
module html_text_stripper (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [hts_pkg::LEN_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // text_byte
  input  logic                      s_tlast,   // is_last
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // out_byte
  output logic                      m_tuser,   // has_byte
  output logic                      m_tlast    // string_done
);

  logic           in_valid;
  logic [7:0]     in_byte;
  logic           in_last;
  logic           room;
  logic           fire;
  hts_pkg::step_t step;

  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hts_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .text_byte (in_byte),
    .is_last   (in_last),
    .step      (step)
  );

  hts_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (fire),
    .step     (step),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: tb/sv/tb_html_text_stripper.sv
module tb_html_text_stripper;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 110;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       done;
  } clean_word_t;

  typedef struct {
    logic [7:0] c;
    logic       l;
  } text_word_t;

  class clean_text_checker;
    string       ent_names[hts_pkg::ENT_COUNT];
    logic [7:0]  ent_glyph[hts_pkg::ENT_COUNT];
    clean_word_t cleaned_q[$];
    logic [hts_pkg::LEN_W-1:0] max_len;
    hts_pkg::mode_t mode;
    logic [7:0]  ent_buf[hts_pkg::ENT_MAX];
    int          ent_cnt;
    bit          after_ws;
    bit          ws_held;
    int          out_cnt;
    int          mismatches;

    function new();
      ent_names = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;", "&apos;", "&nbsp;"};
      ent_glyph = '{hts_pkg::CH_AMP, hts_pkg::CH_LT, hts_pkg::CH_GT, hts_pkg::CH_QUOT,
                    hts_pkg::CH_APOS, hts_pkg::CH_APOS, hts_pkg::CH_SPACE};
      max_len = hts_pkg::LEN_W'(hts_pkg::MAX_OUT_LEN);
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      mode = hts_pkg::MODE_TEXT;
      foreach (ent_buf[i]) ent_buf[i] = 8'h00;
      ent_cnt = 0;
      after_ws = 1'b1;
      ws_held = 1'b0;
      out_cnt = 0;
    endfunction

    function int pending();
      return cleaned_q.size();
    endfunction

    function int out_limit();
      int m;
      m = (max_len > hts_pkg::MAX_OUT_LEN) ? hts_pkg::MAX_OUT_LEN : int'(max_len);
      return (m == 0) ? 0 : m - 1;
    endfunction

    function void put(logic [7:0] d);
      clean_word_t w;
      w.data = d;
      w.has = 1'b1;
      w.done = 1'b0;
      cleaned_q.push_back(w);
      out_cnt++;
    endfunction

    function void emit_char(logic [7:0] d);
      if (ws_held) begin
        put(hts_pkg::CH_SPACE);
        ws_held = 1'b0;
      end
      put(d);
    endfunction

    function void mark_space();
      if (!after_ws) begin
        ws_held = 1'b1;
        after_ws = 1'b1;
      end
    endfunction

    function void entity_step(logic [7:0] c);
      bit partial;
      bit same;
      int len;
      partial = 1'b0;
      if (ent_cnt >= hts_pkg::ENT_MAX) begin
        mode = (c == hts_pkg::CH_SEMI) ? hts_pkg::MODE_TEXT : hts_pkg::MODE_SKIP;
        ent_cnt = 0;
        return;
      end
      ent_buf[ent_cnt] = c;
      ent_cnt++;
      for (int k = 0; k < hts_pkg::ENT_COUNT; k++) begin
        len = ent_names[k].len();
        same = (ent_cnt <= len);
        for (int i = 0; i < ent_cnt && same; i++) begin
          if (ent_buf[i] != ent_names[k][i]) same = 1'b0;
        end
        if (same) begin
          if (ent_cnt == len) begin
            if (k == int'(hts_pkg::ENT_NBSP)) mark_space();
            else emit_char(ent_glyph[k]);
            mode = hts_pkg::MODE_TEXT;
            ent_cnt = 0;
            return;
          end
          partial = 1'b1;
        end
      end
      if (!partial) begin
        mode = (c == hts_pkg::CH_SEMI) ? hts_pkg::MODE_TEXT : hts_pkg::MODE_SKIP;
        ent_cnt = 0;
      end
    endfunction

    function void scan_char(logic [7:0] c);
      case (mode)
        hts_pkg::MODE_TAG: begin
          if (c == hts_pkg::CH_GT) mode = hts_pkg::MODE_TEXT;
        end
        hts_pkg::MODE_SKIP: begin
          if (c == hts_pkg::CH_SEMI) mode = hts_pkg::MODE_TEXT;
        end
        hts_pkg::MODE_ENT: entity_step(c);
        default: begin
          if (c == hts_pkg::CH_LT) begin
            mode = hts_pkg::MODE_TAG;
          end else if (c == hts_pkg::CH_AMP) begin
            ent_buf[0] = hts_pkg::CH_AMP;
            ent_cnt = 1;
            mode = hts_pkg::MODE_ENT;
          end else if (c == hts_pkg::CH_SPACE ||
                       (c >= hts_pkg::CH_TAB && c <= hts_pkg::CH_CR)) begin
            mark_space();
          end else begin
            emit_char(c);
            after_ws = 1'b0;
          end
        end
      endcase
    endfunction

    function void take_char(logic [7:0] c, logic l);
      int base;
      clean_word_t w;
      base = cleaned_q.size();
      if (c != hts_pkg::CH_NUL && out_cnt + int'(ws_held) < out_limit()) scan_char(c);
      if (c == hts_pkg::CH_NUL || l) begin
        if (cleaned_q.size() == base) begin
          w.data = 8'h00;
          w.has = 1'b0;
          w.done = 1'b1;
          cleaned_q.push_back(w);
        end else begin
          cleaned_q[cleaned_q.size() - 1].done = 1'b1;
        end
        clear_string();
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_word(logic [7:0] d, logic h, logic dn);
      clean_word_t w;
      if (cleaned_q.size() == 0) begin
        flag($sformatf("unexpected word: data %02h has %0b done %0b", d, h, dn));
        return;
      end
      w = cleaned_q.pop_front();
      if (w.data !== d || w.has !== h || w.done !== dn)
        flag($sformatf("mismatch: expected data %02h has %0b done %0b, got data %02h has %0b done %0b",
                       w.data, w.has, w.done, d, h, dn));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [hts_pkg::LEN_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = 8'h00;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             m_tuser;
  logic             m_tlast;

  clean_text_checker sb;
  text_word_t        stim_q[$];
  bit                src_gaps = 1'b1;
  bit                snk_gaps = 1'b1;
  int                idle_cycles = 0;

  html_text_stripper dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(bit on);
    return on ? $urandom_range(0, 10) : 0;
  endfunction

  function automatic void add_byte(logic [7:0] c, logic l);
    text_word_t w;
    w.c = c;
    w.l = l;
    stim_q.push_back(w);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endfunction

  function automatic void close_string();
    stim_q[stim_q.size() - 1].l = 1'b1;
  endfunction

  function automatic void add_random_string();
    int         kind;
    int         k;
    int         n;
    logic [7:0] c;
    string      name;
    repeat ($urandom_range(1, 12)) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
      end else if (kind < 38) begin
        add_byte(8'($urandom_range(8'h21, 8'h7e)), 1'b0);
      end else if (kind < 52) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) != 0) add_byte(hts_pkg::CH_SPACE, 1'b0);
          else add_byte(8'($urandom_range(hts_pkg::CH_TAB, hts_pkg::CH_CR)), 1'b0);
        end
      end else if (kind < 60) begin
        add_byte(hts_pkg::CH_LT, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          do c = 8'($urandom_range(8'h20, 8'h7e)); while (c == hts_pkg::CH_GT);
          add_byte(c, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) add_byte(hts_pkg::CH_GT, 1'b0);
      end else if (kind < 78) begin
        add_str(sb.ent_names[$urandom_range(0, hts_pkg::ENT_COUNT - 1)]);
      end else if (kind < 86) begin
        name = sb.ent_names[$urandom_range(0, hts_pkg::ENT_COUNT - 1)];
        n = $urandom_range(1, name.len() - 1);
        for (k = 0; k < n; k++) add_byte(name[k], 1'b0);
        case ($urandom_range(0, 3))
          0: add_byte(hts_pkg::CH_SEMI, 1'b0);
          1: add_byte(hts_pkg::CH_SPACE, 1'b0);
          2: add_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
          default: add_byte(8'($urandom_range(1, 255)), 1'b0);
        endcase
      end else if (kind < 92) begin
        add_byte(hts_pkg::CH_AMP, 1'b0);
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(8'h23, 8'h7a)), 1'b0);
        if ($urandom_range(0, 1) != 0) add_byte(hts_pkg::CH_SEMI, 1'b0);
      end else begin
        add_byte(8'($urandom_range(8'h80, 8'hff)), 1'b0);
      end
    end
    if ($urandom_range(0, 4) != 0) close_string();
    else add_byte(hts_pkg::CH_NUL, 1'($urandom_range(0, 1)));
  endfunction

  function automatic void add_noise_string();
    repeat ($urandom_range(1, 20))
      add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    close_string();
  endfunction

  task automatic send_word(logic [7:0] c, logic l);
    int gap;
    gap = draw_gap(src_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    sb.take_char(c, l);
  endtask

  task automatic send_text();
    text_word_t w;
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      send_word(w.c, w.l);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic set_max_len(logic [hts_pkg::LEN_W-1:0] v);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_len = v;
  endtask

  // sink side: when snk_gaps is set, hold m_tready low for a random gap before each word
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(snk_gaps);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_word(m_tdata, m_tuser, m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_html_text_stripper NOT OK");
      $finish;
    end
  end

  initial begin
    logic [hts_pkg::LEN_W-1:0] plan[8];
    logic [hts_pkg::LEN_W-1:0] v;
    sb = new();
    plan = '{13'd1, 13'd8191, 13'd0, 13'd2, 13'd3, 13'd4097, 13'd4095, 13'd4096};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_byte(hts_pkg::CH_NUL, 1'b0);
    add_str(" <a>&gt; b");
    add_byte(8'hFF, 1'b1);
    add_str("&q;c&nbsp;&lt");
    close_string();
    send_text();

    for (int p = 0; p < PHASES; p++) begin
      v = (p < 8) ? plan[p] : hts_pkg::LEN_W'($urandom_range(4, 24));
      set_max_len(v);
      src_gaps = ($urandom_range(0, 2) != 0);
      snk_gaps = ($urandom_range(0, 2) != 0);
      while (stim_q.size() < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) add_noise_string();
        else add_random_string();
      end
      send_text();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_html_text_stripper OK");
    end else begin
      $display("tb_html_text_stripper NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/hts_pkg.sv
rtl/hts_scan.sv
rtl/hts_outq.sv
rtl/html_text_stripper.sv
tb/sv/tb_html_text_stripper.sv
